// ===== src/erast_pkg.sv =====
// Shared widths, types, codes and helpers of the ellipse rasterizer.
package erast_pkg;

    localparam int RADIUS_BITS = 10;
    localparam int COORD_BITS  = 16;
    localparam int FIELD_W     = 16;

    localparam int OFF_W  = RADIUS_BITS + 1;
    localparam int RSQ_W  = 2 * RADIUS_BITS;
    localparam int GRAD_W = 3 * RADIUS_BITS + 4;
    localparam int MUL_W  = 2 * RADIUS_BITS + 4;
    localparam int DEC_W  = 2 * MUL_W;

    localparam int S_DATA_W = 56;
    localparam int M_DATA_W = 3 * FIELD_W;

    localparam logic KIND_START = 1'b0;
    localparam logic KIND_STEP  = 1'b1;

    typedef logic        [RADIUS_BITS-1:0] rad_t;
    typedef logic signed [OFF_W-1:0]       off_t;
    typedef logic        [RSQ_W-1:0]       rsq_t;
    typedef logic signed [GRAD_W-1:0]      grad_t;
    typedef logic signed [MUL_W-1:0]       mul_t;
    typedef logic signed [DEC_W-1:0]       dec_t;
    typedef logic signed [FIELD_W-1:0]     coord_t;

    typedef enum logic [1:0] {
        PH_R1,
        PH_R2,
        PH_FINAL,
        PH_DONE
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_R2INIT,
        ST_PLAN,
        ST_EMIT,
        ST_UPD_A,
        ST_UPD_B
    } state_t;

    // Wrap to the coordinate width and sign-extend into a full field.
    function automatic coord_t wrap_coord(input coord_t v);
        logic signed [COORD_BITS-1:0] low;
        low = v[COORD_BITS-1:0];
        return coord_t'(low);
    endfunction

endpackage

// ===== src/ellipse_rasterizer_unit.sv =====
// Top level of the midpoint ellipse rasterizer.
// A start request (tuser kind 0) loads center, radii and fill mode; it returns no result
// and makes three passes through the shared multiplier before the block is ready again.
// Each step request (kind 1) runs one iteration and returns its points or spans one per
// cycle while the output is not stalled; the block takes no new request until the step
// is done. The step that crosses from region one to region two first builds the region-two
// decision value from five products on the same multiplier. In outline mode a step returns
// two or four points; in filled mode two spans
// (none in region one while the decision value is negative), and a last step returns the
// center span. tlast marks the last result of a step and tuser marks the result that
// completes the ellipse. A step while no ellipse is in progress returns nothing.
module ellipse_rasterizer_unit (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // fill_mode, center_x, center_y, radius_x, radius_y, zero pad
    input  logic [erast_pkg::S_DATA_W-1:0]     s_tdata,
    // kind
    input  logic [0:0]                         s_tuser,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // x_start, x_end, row
    output logic [erast_pkg::M_DATA_W-1:0]     m_tdata,
    output logic                               m_tlast,
    // shape_done
    output logic [0:0]                         m_tuser
);

    erast_pkg::state_t state_reg, state_next;
    erast_pkg::phase_t phase_reg, phase_next;
    logic              filled_reg, filled_next;
    erast_pkg::coord_t ctr_x_reg, ctr_x_next;
    erast_pkg::coord_t ctr_y_reg, ctr_y_next;
    erast_pkg::rad_t   semi_x_reg, semi_x_next;
    erast_pkg::off_t   off_x_reg, off_x_next;
    erast_pkg::off_t   off_y_reg, off_y_next;
    erast_pkg::rsq_t   rx2_reg, rx2_next;
    erast_pkg::rsq_t   ry2_reg, ry2_next;
    erast_pkg::grad_t  grad_x_reg, grad_x_next;
    erast_pkg::grad_t  grad_y_reg, grad_y_next;
    erast_pkg::dec_t   dec_reg, dec_next;
    erast_pkg::mul_t   tmp_reg, tmp_next;
    logic [2:0]        mstep_reg, mstep_next;
    logic [1:0]        idx_reg, idx_next;
    logic [1:0]        last_idx_reg, last_idx_next;

    logic                              m_valid_reg, m_valid_next;
    logic [erast_pkg::M_DATA_W-1:0]    m_data_reg, m_data_next;
    logic                              m_last_reg, m_last_next;
    logic                              m_done_reg, m_done_next;

    erast_pkg::mul_t   mul_a, mul_b;
    erast_pkg::dec_t   prod;

    logic              in_kind, in_fill;
    erast_pkg::coord_t in_cx, in_cy;
    erast_pkg::rad_t   in_rx, in_ry;

    erast_pkg::off_t   t_off;
    logic [erast_pkg::RSQ_W:0] rx2_p3;
    erast_pkg::grad_t  two_rx2, two_ry2;
    logic              dec_neg, dec_pos;
    erast_pkg::phase_t eff_phase;
    logic [2:0]        plan_cnt;
    logic              use_gx, use_gy;
    erast_pkg::dec_t   upd_sq;

    erast_pkg::coord_t ox, oy, span_off, res_x, res_row, res_xs, res_xe;
    logic              res_done, is_last;

    assign in_kind = s_tuser[0];
    assign in_fill = s_tdata[0];
    assign in_cx   = erast_pkg::coord_t'(s_tdata[16:1]);
    assign in_cy   = erast_pkg::coord_t'(s_tdata[32:17]);
    assign in_rx   = erast_pkg::rad_t'(s_tdata[42:33]);
    assign in_ry   = erast_pkg::rad_t'(s_tdata[52:43]);

    assign s_tready = (state_reg == erast_pkg::ST_IDLE);

    erast_mul u_mul (
        .aclk  (aclk),
        .mul_a (mul_a),
        .mul_b (mul_b),
        .prod  (prod)
    );

    assign t_off   = off_y_reg - erast_pkg::off_t'(1);
    assign rx2_p3  = {1'b0, rx2_reg} + (erast_pkg::RSQ_W + 1)'(3);
    assign two_rx2 = erast_pkg::grad_t'(rx2_reg) <<< 1;
    assign two_ry2 = erast_pkg::grad_t'(ry2_reg) <<< 1;
    assign dec_neg = dec_reg[erast_pkg::DEC_W-1];
    assign dec_pos = !dec_neg && (dec_reg != '0);

    // Region two with filled spans ends on the center span.
    always_comb begin
        eff_phase = phase_reg;
        if (phase_reg == erast_pkg::PH_R2 && filled_reg &&
            (off_y_reg[erast_pkg::OFF_W-1] || off_y_reg == '0)) begin
            eff_phase = erast_pkg::PH_FINAL;
        end
    end

    always_comb begin
        plan_cnt = 3'd0;
        unique case (eff_phase)
            erast_pkg::PH_FINAL: plan_cnt = 3'd1;
            erast_pkg::PH_R1: begin
                if (!filled_reg) begin
                    plan_cnt = (off_x_reg != '0) ? 3'd4 : 3'd2;
                end else begin
                    plan_cnt = dec_neg ? 3'd0 : 3'd2;
                end
            end
            erast_pkg::PH_R2: begin
                if (!filled_reg) begin
                    plan_cnt = (off_y_reg != '0) ? 3'd4 : 3'd2;
                end else begin
                    plan_cnt = 3'd2;
                end
            end
            erast_pkg::PH_DONE: plan_cnt = 3'd0;
        endcase
    end

    // Terms of the decision update after the offsets move.
    always_comb begin
        if (phase_reg == erast_pkg::PH_R1) begin
            use_gx = 1'b1;
            use_gy = !dec_neg;
            upd_sq = erast_pkg::dec_t'(ry2_reg);
        end else begin
            use_gx = !dec_pos;
            use_gy = 1'b1;
            upd_sq = erast_pkg::dec_t'(rx2_reg);
        end
    end

    // Result of the current emit index.
    always_comb begin
        ox       = erast_pkg::coord_t'(off_x_reg);
        oy       = erast_pkg::coord_t'(off_y_reg);
        span_off = ox;
        res_x    = ctr_x_reg;
        res_row  = ctr_y_reg;
        if (phase_reg == erast_pkg::PH_FINAL) begin
            span_off = erast_pkg::coord_t'(semi_x_reg);
            res_row  = ctr_y_reg;
        end else if (filled_reg) begin
            res_row = idx_reg[0] ? ctr_y_reg - oy : ctr_y_reg + oy;
        end else begin
            res_x   = (idx_reg == 2'd0 || idx_reg == 2'd3) ? ctr_x_reg + ox : ctr_x_reg - ox;
            res_row = (idx_reg == 2'd0 || idx_reg == 2'd2) ? ctr_y_reg + oy : ctr_y_reg - oy;
        end
        if (filled_reg || phase_reg == erast_pkg::PH_FINAL) begin
            res_xs = ctr_x_reg - span_off;
            res_xe = (span_off != '0) ? ctr_x_reg + span_off - erast_pkg::coord_t'(1) : res_xs;
        end else begin
            res_xs = res_x;
            res_xe = res_x;
        end
        is_last  = (idx_reg == last_idx_reg);
        res_done = (phase_reg == erast_pkg::PH_FINAL) ||
                   (phase_reg == erast_pkg::PH_R2 && !filled_reg && off_y_reg == '0);
    end

    always_comb begin
        state_next    = state_reg;
        phase_next    = phase_reg;
        filled_next   = filled_reg;
        ctr_x_next    = ctr_x_reg;
        ctr_y_next    = ctr_y_reg;
        semi_x_next   = semi_x_reg;
        off_x_next    = off_x_reg;
        off_y_next    = off_y_reg;
        rx2_next      = rx2_reg;
        ry2_next      = ry2_reg;
        grad_x_next   = grad_x_reg;
        grad_y_next   = grad_y_reg;
        dec_next      = dec_reg;
        tmp_next      = tmp_reg;
        mstep_next    = mstep_reg;
        idx_next      = idx_reg;
        last_idx_next = last_idx_reg;
        mul_a         = '0;
        mul_b         = '0;
        m_valid_next  = m_tready ? 1'b0 : m_valid_reg;
        m_data_next   = m_data_reg;
        m_last_next   = m_last_reg;
        m_done_next   = m_done_reg;

        unique case (state_reg)
            erast_pkg::ST_IDLE: begin
                if (s_tvalid) begin
                    if (in_kind == erast_pkg::KIND_START) begin
                        filled_next = in_fill;
                        ctr_x_next  = in_cx;
                        ctr_y_next  = in_cy;
                        semi_x_next = in_rx;
                        off_x_next  = '0;
                        off_y_next  = erast_pkg::off_t'(in_ry);
                        grad_x_next = '0;
                        phase_next  = erast_pkg::PH_R1;
                        mstep_next  = '0;
                        state_next  = erast_pkg::ST_SETUP;
                    end else begin
                        priority if (phase_reg == erast_pkg::PH_DONE) begin
                            state_next = erast_pkg::ST_IDLE;
                        end else if (phase_reg == erast_pkg::PH_R1 &&
                                     !(grad_x_reg < grad_y_reg)) begin
                            mstep_next = '0;
                            state_next = erast_pkg::ST_R2INIT;
                        end else begin
                            state_next = erast_pkg::ST_PLAN;
                        end
                    end
                end
            end

            erast_pkg::ST_SETUP: begin
                mstep_next = mstep_reg + 3'd1;
                case (mstep_reg)
                    3'd0: begin
                        mul_a = erast_pkg::mul_t'(semi_x_reg);
                        mul_b = erast_pkg::mul_t'(semi_x_reg);
                    end
                    3'd1: begin
                        rx2_next = erast_pkg::rsq_t'(prod);
                        mul_a    = erast_pkg::mul_t'(off_y_reg);
                        mul_b    = erast_pkg::mul_t'(off_y_reg);
                    end
                    3'd2: begin
                        ry2_next = erast_pkg::rsq_t'(prod);
                        mul_a    = erast_pkg::mul_t'(rx2_reg);
                        mul_b    = erast_pkg::mul_t'(off_y_reg);
                    end
                    default: begin
                        // decision = ry2 - rx2*ry + ceil(rx2/4)
                        grad_y_next = erast_pkg::grad_t'(prod) <<< 1;
                        dec_next    = erast_pkg::dec_t'(ry2_reg) - prod +
                                      erast_pkg::dec_t'(rx2_p3[erast_pkg::RSQ_W:2]);
                        state_next  = erast_pkg::ST_IDLE;
                    end
                endcase
            end

            erast_pkg::ST_R2INIT: begin
                // decision = ry2*(ox*ox+ox+1) + rx2*(oy-1)^2 - rx2*ry2
                mstep_next = mstep_reg + 3'd1;
                case (mstep_reg)
                    3'd0: begin
                        mul_a = erast_pkg::mul_t'(off_x_reg);
                        mul_b = erast_pkg::mul_t'(off_x_reg);
                    end
                    3'd1: begin
                        tmp_next = erast_pkg::mul_t'(prod) + erast_pkg::mul_t'(off_x_reg) +
                                   erast_pkg::mul_t'(1);
                        mul_a    = erast_pkg::mul_t'(t_off);
                        mul_b    = erast_pkg::mul_t'(t_off);
                    end
                    3'd2: begin
                        tmp_next = erast_pkg::mul_t'(prod);
                        mul_a    = erast_pkg::mul_t'(ry2_reg);
                        mul_b    = tmp_reg;
                    end
                    3'd3: begin
                        dec_next = prod;
                        mul_a    = erast_pkg::mul_t'(rx2_reg);
                        mul_b    = tmp_reg;
                    end
                    3'd4: begin
                        dec_next = dec_reg + prod;
                        mul_a    = erast_pkg::mul_t'(rx2_reg);
                        mul_b    = erast_pkg::mul_t'(ry2_reg);
                    end
                    default: begin
                        dec_next   = dec_reg - prod;
                        phase_next = erast_pkg::PH_R2;
                        state_next = erast_pkg::ST_PLAN;
                    end
                endcase
            end

            erast_pkg::ST_PLAN: begin
                if (phase_reg == erast_pkg::PH_R2 && !filled_reg &&
                    off_y_reg[erast_pkg::OFF_W-1]) begin
                    phase_next = erast_pkg::PH_DONE;
                    state_next = erast_pkg::ST_IDLE;
                end else begin
                    phase_next = eff_phase;
                    if (plan_cnt == 3'd0) begin
                        state_next = erast_pkg::ST_UPD_A;
                    end else begin
                        idx_next      = '0;
                        last_idx_next = 2'(plan_cnt - 3'd1);
                        state_next    = erast_pkg::ST_EMIT;
                    end
                end
            end

            erast_pkg::ST_EMIT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = {erast_pkg::wrap_coord(res_row),
                                    erast_pkg::wrap_coord(res_xe),
                                    erast_pkg::wrap_coord(res_xs)};
                    m_last_next  = is_last;
                    m_done_next  = is_last && res_done;
                    if (is_last) begin
                        if (phase_reg == erast_pkg::PH_FINAL) begin
                            phase_next = erast_pkg::PH_DONE;
                            state_next = erast_pkg::ST_IDLE;
                        end else begin
                            state_next = erast_pkg::ST_UPD_A;
                        end
                    end else begin
                        idx_next = idx_reg + 2'd1;
                    end
                end
            end

            erast_pkg::ST_UPD_A: begin
                // Advance offsets and gradients; decision sign is still the old one.
                if (phase_reg == erast_pkg::PH_R1) begin
                    off_x_next  = off_x_reg + erast_pkg::off_t'(1);
                    grad_x_next = grad_x_reg + two_ry2;
                    if (!dec_neg) begin
                        off_y_next  = off_y_reg - erast_pkg::off_t'(1);
                        grad_y_next = grad_y_reg - two_rx2;
                    end
                end else begin
                    off_y_next  = off_y_reg - erast_pkg::off_t'(1);
                    grad_y_next = grad_y_reg - two_rx2;
                    if (!dec_pos) begin
                        off_x_next  = off_x_reg + erast_pkg::off_t'(1);
                        grad_x_next = grad_x_reg + two_ry2;
                    end
                end
                state_next = erast_pkg::ST_UPD_B;
            end

            erast_pkg::ST_UPD_B: begin
                dec_next = dec_reg +
                           (use_gx ? erast_pkg::dec_t'(grad_x_reg) : erast_pkg::dec_t'(0)) -
                           (use_gy ? erast_pkg::dec_t'(grad_y_reg) : erast_pkg::dec_t'(0)) +
                           upd_sq;
                if (phase_reg == erast_pkg::PH_R2 && !filled_reg &&
                    off_y_reg[erast_pkg::OFF_W-1]) begin
                    phase_next = erast_pkg::PH_DONE;
                end
                state_next = erast_pkg::ST_IDLE;
            end

            default: state_next = erast_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= erast_pkg::ST_IDLE;
            phase_reg   <= erast_pkg::PH_DONE;
            filled_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            phase_reg   <= phase_next;
            filled_reg  <= filled_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ctr_x_reg    <= ctr_x_next;
        ctr_y_reg    <= ctr_y_next;
        semi_x_reg   <= semi_x_next;
        off_x_reg    <= off_x_next;
        off_y_reg    <= off_y_next;
        rx2_reg      <= rx2_next;
        ry2_reg      <= ry2_next;
        grad_x_reg   <= grad_x_next;
        grad_y_reg   <= grad_y_next;
        dec_reg      <= dec_next;
        tmp_reg      <= tmp_next;
        mstep_reg    <= mstep_next;
        idx_reg      <= idx_next;
        last_idx_reg <= last_idx_next;
        m_data_reg   <= m_data_next;
        m_last_reg   <= m_last_next;
        m_done_reg   <= m_done_next;
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = m_data_reg;
    assign m_tlast    = m_last_reg;
    assign m_tuser[0] = m_done_reg;

endmodule

// ===== src/erast_mul.sv =====
// Shared signed multiplier with a registered product.
module erast_mul (
    input  logic             aclk,
    input  erast_pkg::mul_t  mul_a,
    input  erast_pkg::mul_t  mul_b,
    output erast_pkg::dec_t  prod
);

    erast_pkg::dec_t prod_reg;

    always_ff @(posedge aclk) begin
        prod_reg <= erast_pkg::dec_t'(mul_a * mul_b);
    end

    assign prod = prod_reg;

endmodule

// ===== src/erast_checker.sv =====
// Port-level checks of the ellipse rasterizer and their binding to the top level.
module erast_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [erast_pkg::M_DATA_W-1:0] m_tdata,
    input logic                           m_tlast,
    input logic [0:0]                     m_tuser
);

    // A stalled result holds.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast) &&
                                  $stable(m_tuser))
        else $error("stalled result changed");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result shown right after reset");

    // While no result is shown, none appears in the cycle after a request is taken.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result shown directly after a request");

    // Completion is flagged only on the last result of a step.
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("shape_done without last_of_step");

    // More results of the step are pending: no new request is taken.
    a_busy_mid_step: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tlast |-> !s_tready)
        else $error("request taken in the middle of a step");

endmodule

bind ellipse_rasterizer_unit erast_checker u_erast_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
);

// ===== test/tb_ellipse_rasterizer_unit.sv =====
// Self-checking testbench for the ellipse rasterizer: a predictor traces each request, and every result is checked.
`timescale 1ns / 100ps

module tb_ellipse_rasterizer_unit;

    typedef struct packed {
        erast_pkg::coord_t x_start;
        erast_pkg::coord_t x_end;
        erast_pkg::coord_t row;
        logic              last_of_step;
        logic              shape_done;
    } pixel_t;

    logic                           aclk     = 1'b0;
    logic                           aresetn  = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [erast_pkg::S_DATA_W-1:0] s_tdata  = '0;
    logic [0:0]                     s_tuser  = erast_pkg::KIND_START;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [erast_pkg::M_DATA_W-1:0] m_tdata;
    logic                           m_tlast;
    logic [0:0]                     m_tuser;

    // Traced ellipse state
    longint el_cx, el_cy, el_semi, el_ox, el_oy;
    longint el_rx2, el_ry2, el_gx, el_gy, el_dec;
    erast_pkg::phase_t el_phase  = erast_pkg::PH_DONE;
    logic              el_filled = 1'b0;

    pixel_t expected_pixels[$];
    bit     calm = 1'b0;
    int     stall_left = 0;
    int     errors = 0;
    int     active_requests = 0;
    int     shapes_started = 0;
    int     filled_started = 0;
    int     pixels_checked = 0;
    int     shapes_closed = 0;

    ellipse_rasterizer_unit dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        if (errors <= 40)
            $display("MISMATCH at %0t: %s", $time, msg);
    endtask

    // COORD_BITS equals the field width, so wrapping is plain truncation
    function automatic pixel_t make_pixel(input longint xs, input longint xe, input longint row);
        pixel_t p;
        p.x_start      = xs[erast_pkg::FIELD_W-1:0];
        p.x_end        = xe[erast_pkg::FIELD_W-1:0];
        p.row          = row[erast_pkg::FIELD_W-1:0];
        p.last_of_step = 1'b0;
        p.shape_done   = 1'b0;
        return p;
    endfunction

    // Span stops one pixel short of the right edge, except a zero offset
    function automatic pixel_t make_span(input longint off, input longint row);
        longint xs;
        xs = el_cx - off;
        return make_pixel(xs, (off != 0) ? el_cx + off - 1 : xs, row);
    endfunction

    function automatic void trace_ellipse_request(input logic kind, input logic fill,
                                                  input erast_pkg::coord_t cx,
                                                  input erast_pkg::coord_t cy,
                                                  input erast_pkg::rad_t rx,
                                                  input erast_pkg::rad_t ry);
        pixel_t px[$];
        logic   fin;
        longint t;
        fin = 1'b0;
        if (kind == erast_pkg::KIND_START) begin
            el_filled = fill;
            el_cx     = longint'(cx);
            el_cy     = longint'(cy);
            el_semi   = longint'(rx);
            el_ox     = 0;
            el_oy     = longint'(ry);
            el_rx2    = longint'(rx) * longint'(rx);
            el_ry2    = longint'(ry) * longint'(ry);
            el_dec    = el_ry2 - el_rx2 * el_oy + ((el_rx2 + 3) >> 2);
            el_gx     = 0;
            el_gy     = 2 * el_rx2 * el_oy;
            el_phase  = erast_pkg::PH_R1;
            return;
        end
        if (el_phase == erast_pkg::PH_DONE)
            return;
        if (el_phase == erast_pkg::PH_R1 && !(el_gx < el_gy)) begin
            t = el_oy - 1;
            el_dec = el_ry2 * (el_ox * el_ox + el_ox + 1) + el_rx2 * (t * t) - el_rx2 * el_ry2;
            el_phase = erast_pkg::PH_R2;
        end
        if (el_phase == erast_pkg::PH_R2) begin
            if (el_filled && el_oy <= 0) begin
                el_phase = erast_pkg::PH_FINAL;
            end else if (!el_filled && el_oy < 0) begin
                el_phase = erast_pkg::PH_DONE;
                return;
            end
        end
        case (el_phase)
            erast_pkg::PH_R1: begin
                if (!el_filled) begin
                    px.push_back(make_pixel(el_cx + el_ox, el_cx + el_ox, el_cy + el_oy));
                    px.push_back(make_pixel(el_cx - el_ox, el_cx - el_ox, el_cy - el_oy));
                    if (el_ox != 0) begin
                        px.push_back(make_pixel(el_cx - el_ox, el_cx - el_ox, el_cy + el_oy));
                        px.push_back(make_pixel(el_cx + el_ox, el_cx + el_ox, el_cy - el_oy));
                    end
                end else if (el_dec >= 0) begin
                    px.push_back(make_span(el_ox, el_cy + el_oy));
                    px.push_back(make_span(el_ox, el_cy - el_oy));
                end
                el_ox++;
                el_gx += 2 * el_ry2;
                if (el_dec < 0) begin
                    el_dec += el_gx + el_ry2;
                end else begin
                    el_oy--;
                    el_gy -= 2 * el_rx2;
                    el_dec += el_gx - el_gy + el_ry2;
                end
            end
            erast_pkg::PH_R2: begin
                if (!el_filled) begin
                    px.push_back(make_pixel(el_cx + el_ox, el_cx + el_ox, el_cy + el_oy));
                    px.push_back(make_pixel(el_cx - el_ox, el_cx - el_ox, el_cy - el_oy));
                    if (el_oy != 0) begin
                        px.push_back(make_pixel(el_cx - el_ox, el_cx - el_ox, el_cy + el_oy));
                        px.push_back(make_pixel(el_cx + el_ox, el_cx + el_ox, el_cy - el_oy));
                    end
                end else begin
                    px.push_back(make_span(el_ox, el_cy + el_oy));
                    px.push_back(make_span(el_ox, el_cy - el_oy));
                end
                el_oy--;
                el_gy -= 2 * el_rx2;
                if (el_dec > 0) begin
                    el_dec += el_rx2 - el_gy;
                end else begin
                    el_ox++;
                    el_gx += 2 * el_ry2;
                    el_dec += el_gx - el_gy + el_rx2;
                end
                if (!el_filled && el_oy < 0) begin
                    el_phase = erast_pkg::PH_DONE;
                    fin = 1'b1;
                end
            end
            default: begin
                px.push_back(make_span(el_semi, el_cy));
                el_phase = erast_pkg::PH_DONE;
                fin = 1'b1;
            end
        endcase
        if (px.size() > 0) begin
            px[px.size()-1].last_of_step = 1'b1;
            px[px.size()-1].shape_done   = fin;
        end
        foreach (px[i])
            expected_pixels.push_back(px[i]);
    endfunction

    // Valid stays high into the next request when there is no gap
    task automatic send_request(input logic kind, input logic fill,
                                input erast_pkg::coord_t cx, input erast_pkg::coord_t cy,
                                input erast_pkg::rad_t rx, input erast_pkg::rad_t ry);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 7);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {3'b000, ry, rx, cy, cx, fill};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        if (kind == erast_pkg::KIND_START || el_phase != erast_pkg::PH_DONE)
            active_requests++;
        if (kind == erast_pkg::KIND_START) begin
            shapes_started++;
            if (fill)
                filled_started++;
        end
        trace_ellipse_request(kind, fill, cx, cy, rx, ry);
    endtask

    // Step requests carry random payload, which the block ignores
    task automatic step_until_done(input int max_steps);
        int n;
        n = 0;
        while (el_phase != erast_pkg::PH_DONE && n < max_steps) begin
            send_request(erast_pkg::KIND_STEP, 1'($urandom), erast_pkg::coord_t'($urandom),
                         erast_pkg::coord_t'($urandom), erast_pkg::rad_t'($urandom),
                         erast_pkg::rad_t'($urandom));
            n++;
        end
    endtask

    task automatic run_shape(input logic fill, input erast_pkg::coord_t cx,
                             input erast_pkg::coord_t cy, input erast_pkg::rad_t rx,
                             input erast_pkg::rad_t ry, input int max_steps);
        send_request(erast_pkg::KIND_START, fill, cx, cy, rx, ry);
        step_until_done(max_steps);
    endtask

    // Hold off the sender until every pending result is back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_pixels.size() != 0) @(posedge aclk);
    endtask

    task automatic check_pixel(input logic [erast_pkg::M_DATA_W-1:0] data, input logic last,
                               input logic done);
        pixel_t            want;
        erast_pkg::coord_t xs, xe, row;
        xs  = data[erast_pkg::FIELD_W-1:0];
        xe  = data[2*erast_pkg::FIELD_W-1:erast_pkg::FIELD_W];
        row = data[3*erast_pkg::FIELD_W-1:2*erast_pkg::FIELD_W];
        if (expected_pixels.size() == 0) begin
            report_mismatch($sformatf("unexpected result x %0d..%0d row %0d", xs, xe, row));
            return;
        end
        want = expected_pixels.pop_front();
        pixels_checked++;
        if (xs !== want.x_start)
            report_mismatch($sformatf("x_start %0d, want %0d", xs, want.x_start));
        if (xe !== want.x_end)
            report_mismatch($sformatf("x_end %0d, want %0d", xe, want.x_end));
        if (row !== want.row)
            report_mismatch($sformatf("row %0d, want %0d", row, want.row));
        if (last !== want.last_of_step)
            report_mismatch($sformatf("last_of_step %0b, want %0b", last, want.last_of_step));
        if (done !== want.shape_done)
            report_mismatch($sformatf("shape_done %0b, want %0b", done, want.shape_done));
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                check_pixel(m_tdata, m_tlast, m_tuser[0]);
                if (m_tuser[0] === 1'b1)
                    shapes_closed++;
                stall_left = calm ? 0 : $urandom_range(0, 7);
            end else if (stall_left > 0) begin
                stall_left--;
            end else if (!calm && $urandom_range(0, 15) == 0) begin
                stall_left = $urandom_range(1, 7);
            end
            m_tready <= (stall_left == 0);
        end
    end

    task automatic test_idle_steps();
        send_request(erast_pkg::KIND_STEP, 1'b1, 16'sh7fff, -16'sh8000, 10'h3ff, 10'h3ff);
        send_request(erast_pkg::KIND_STEP, 1'b0, '0, '0, '0, '0);
    endtask

    task automatic test_outline_shapes();
        run_shape(1'b0, 16'sd0, 16'sd0, 10'd0, 10'd0, 50);
        send_request(erast_pkg::KIND_STEP, 1'b0, '0, '0, '0, '0);
        run_shape(1'b0, -16'sd20, 16'sd7, 10'd5, 10'd0, 50);
        run_shape(1'b0, 16'sd3, -16'sd3, 10'd0, 10'd2, 50);
    endtask

    task automatic test_filled_shapes();
        run_shape(1'b1, 16'sd100, -16'sd50, 10'd3, 10'd2, 50);
        run_shape(1'b1, 16'sd0, 16'sd0, 10'd0, 10'd0, 50);
    endtask

    // Largest radii at the corners of the coordinate range: rows and columns wrap
    task automatic test_extreme_coords();
        run_shape(1'b0, 16'sh7fff, -16'sh8000, 10'h3ff, 10'h3ff, 3);
        run_shape(1'b1, -16'sh8000, 16'sh7fff, 10'h3ff, 10'h3ff, 3);
    endtask

    task automatic test_pause_midshape();
        run_shape(1'b1, -16'sd9, 16'sd12, 10'd7, 10'd5, 3);
        wait_for_results();
        step_until_done(200);
        wait_for_results();
    endtask

    task automatic test_random_shapes(input int target);
        int                pick;
        int                shapes;
        erast_pkg::coord_t cx, cy;
        shapes = 0;
        while (active_requests < target) begin
            pick = $urandom_range(0, 19);
            calm = ($urandom_range(0, 4) == 0);
            cx   = erast_pkg::coord_t'($urandom);
            cy   = erast_pkg::coord_t'($urandom);
            if ($urandom_range(0, 3) == 0)
                cx = 16'sh7ffc + erast_pkg::coord_t'($urandom_range(0, 7));
            if ($urandom_range(0, 3) == 0)
                cy = 16'sh7ffc + erast_pkg::coord_t'($urandom_range(0, 7));
            if (pick < 14) begin
                run_shape(1'($urandom), cx, cy, erast_pkg::rad_t'($urandom_range(0, 8)),
                          erast_pkg::rad_t'($urandom_range(0, 8)), 1000);
                if ($urandom_range(0, 3) == 0)
                    step_until_done(1);
            end else if (pick < 17) begin
                // Cut short: the next start drops the ellipse in progress
                run_shape(1'($urandom), cx, cy, erast_pkg::rad_t'($urandom),
                          erast_pkg::rad_t'($urandom), $urandom_range(0, 6));
            end else begin
                repeat ($urandom_range(1, 3))
                    send_request(erast_pkg::KIND_STEP, 1'($urandom),
                                 erast_pkg::coord_t'($urandom), erast_pkg::coord_t'($urandom),
                                 erast_pkg::rad_t'($urandom), erast_pkg::rad_t'($urandom));
            end
            shapes++;
            if (shapes % 8 == 0)
                wait_for_results();
        end
        calm = 1'b0;
    endtask

    initial begin
        int waited;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_idle_steps();
        test_outline_shapes();
        test_filled_shapes();
        test_extreme_coords();
        test_pause_midshape();
        test_random_shapes(280);
        s_tvalid <= 1'b0;
        waited = 0;
        while (expected_pixels.size() != 0 && waited < 5000) begin
            @(posedge aclk);
            waited++;
        end
        repeat (16) @(posedge aclk);
        if (expected_pixels.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", expected_pixels.size()));
        $display("Covered %0d working requests over %0d ellipses (%0d filled)",
                 active_requests, shapes_started, filled_started);
        $display("Checked %0d results, %0d ellipses closed, %0d mismatches",
                 pixels_checked, shapes_closed, errors);
        if (errors == 0) begin
            $display("tb_ellipse_rasterizer_unit OK");
        end else begin
            $display("tb_ellipse_rasterizer_unit NOT OK");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("tb_ellipse_rasterizer_unit NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
src/erast_pkg.sv
src/erast_mul.sv
src/ellipse_rasterizer_unit.sv
src/erast_checker.sv
test/tb_ellipse_rasterizer_unit.sv
